// File: design/isa_pkg.sv
// Shared types and constants for the interrupt slot allocator.
// Used by isa_ctrl, isa_datapath and the top level; depends on nothing.

package isa_pkg;

  // Table size and source range
  localparam int SLOTS       = 6;
  localparam int NUM_SOURCES = 136;
  localparam int LINE_REGS   = 6;
  localparam int SLOT_IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int SRC_W    = 8;
  localparam int SLOT_W   = 3;
  localparam int WORD_W   = 32;
  localparam int LINE_W   = 6;
  localparam int CODE_W   = 2;
  localparam int ACT_W    = 2;
  localparam int CFG_IW   = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EVENT   = 3'd4;

  // Result codes
  localparam logic [CODE_W-1:0] RC_OK      = 2'd0;
  localparam logic [CODE_W-1:0] RC_INVALID = 2'd1;
  localparam logic [CODE_W-1:0] RC_HELD    = 2'd2;
  localparam logic [CODE_W-1:0] RC_FULL    = 2'd3;

  // Line actions
  localparam logic [ACT_W-1:0] LA_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] LA_ENABLE  = 2'd1;
  localparam logic [ACT_W-1:0] LA_DISABLE = 2'd2;

  // Register indexes and reset values
  localparam logic [CFG_IW-1:0] REG_PARKED = 3'd6;
  localparam int                LINE_RESET_BASE = 16;
  localparam logic [LINE_W-1:0] PARKED_RESET    = 6'd22;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic exec;
  } isa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic alloc_scan;
    logic scan_last;
    logic out_full;
  } isa_stat_t;

endpackage

// File: design/isa_ctrl.sv
// Sequencer for the interrupt slot allocator: accept, slot scan, execute.
// Depends on isa_pkg; drives commands into isa_datapath.

module isa_ctrl
  import isa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_stall,
  input  isa_stat_t stat,
  output isa_cmd_t  ctrl_cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  // Decode commands from the current state
  always_comb begin
    in_stall           = (state != S_IDLE);
    ctrl_cmd.capture   = (state == S_IDLE) && in_valid;
    ctrl_cmd.scan_step = (state == S_SCAN);
    ctrl_cmd.exec      = (state == S_EXEC) && (!stat.out_full || !out_stall);
  end

  // Advance through scan and execute
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.alloc_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (ctrl_cmd.exec) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Never overwrite a result that the receiver has not taken
  a_exec_room: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.exec |-> (!stat.out_full || !out_stall))
    else $error("execute issued while result register blocked");

  // A scan only follows an accepted transaction or another scan step
  a_scan_origin: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.scan_step |-> ($past(ctrl_cmd.capture) || $past(ctrl_cmd.scan_step)))
    else $error("scan step without a captured transaction");

endmodule

// File: design/isa_datapath.sv
// Datapath of the interrupt slot allocator: line registers, slot table,
// scan flags, result decision and the output register. Depends on isa_pkg.

module isa_datapath
  import isa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  isa_cmd_t            ctrl_cmd,
  output isa_stat_t           stat,
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [LINE_W-1:0]   cfg_data,
  // input fields
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SRC_W-1:0]    source,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [WORD_W-1:0]   handler_ref,
  input  logic [WORD_W-1:0]   arg_ref,
  input  logic                filter_on,
  input  logic [WORD_W-1:0]   filter_mask,
  input  logic [WORD_W-1:0]   status_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   result_code,
  output logic [SLOT_W-1:0]   slot_out,
  output logic                route_valid,
  output logic [SRC_W-1:0]    route_source,
  output logic [LINE_W-1:0]   route_value,
  output logic [ACT_W-1:0]    line_action,
  output logic [LINE_W-1:0]   line_number,
  output logic                dispatch,
  output logic [WORD_W-1:0]   dispatch_handler,
  output logic [WORD_W-1:0]   dispatch_arg
);

  // Configuration registers
  logic [LINE_W-1:0] line_reg [LINE_REGS];
  logic [LINE_W-1:0] parked;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_REGS; i++) begin
        line_reg[i] <= LINE_W'(LINE_RESET_BASE + i);
      end
      parked <= PARKED_RESET;
    end else if (cfg_we) begin
      if ({1'b0, cfg_index} < (CFG_IW + 1)'(LINE_REGS)) begin
        line_reg[cfg_index] <= cfg_data;
      end else if (cfg_index == REG_PARKED) begin
        parked <= cfg_data;
      end
    end
  end

  // Captured transaction
  logic [CMD_W-1:0]  cmd_q;
  logic [SRC_W-1:0]  src_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WORD_W-1:0] handler_q;
  logic [WORD_W-1:0] arg_q;
  logic              fon_q;
  logic [WORD_W-1:0] fmask_q;
  logic [WORD_W-1:0] status_q;

  always_ff @(posedge clk) begin
    if (ctrl_cmd.capture) begin
      cmd_q     <= cmd;
      src_q     <= source;
      slot_q    <= slot;
      handler_q <= handler_ref;
      arg_q     <= arg_ref;
      fon_q     <= filter_on;
      fmask_q   <= filter_mask;
      status_q  <= status_value;
    end
  end

  // Slot table
  logic              slot_busy    [SLOTS];
  logic              slot_enabled [SLOTS];
  logic [SRC_W-1:0]  slot_source  [SLOTS];
  logic              slot_fon     [SLOTS];
  logic [WORD_W-1:0] slot_mask    [SLOTS];
  logic [WORD_W-1:0] slot_handler [SLOTS];
  logic [WORD_W-1:0] slot_arg     [SLOTS];

  // Scan state
  logic [SLOT_IW-1:0] scan_idx;
  logic               dup;
  logic               found;
  logic [SLOT_IW-1:0] found_idx;

  // Decide whether an alloc needs the scan at all
  always_comb begin
    stat.alloc_scan = (cmd == CMD_ALLOC) &&
                      ({1'b0, source} < (SRC_W + 1)'(NUM_SOURCES)) &&
                      (handler_ref != '0);
    stat.scan_last  = (scan_idx == SLOT_IW'(SLOTS - 1));
    stat.out_full   = out_valid;
  end

  // Walk the table one slot per cycle: duplicate check and first free
  always_ff @(posedge clk) begin
    if (ctrl_cmd.capture) begin
      scan_idx  <= '0;
      dup       <= 1'b0;
      found     <= 1'b0;
      found_idx <= '0;
    end else if (ctrl_cmd.scan_step) begin
      if (slot_busy[scan_idx] && (slot_source[scan_idx] == src_q)) begin
        dup <= 1'b1;
      end
      if (!slot_busy[scan_idx] && !found) begin
        found     <= 1'b1;
        found_idx <= scan_idx;
      end
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // Target slot and its fields
  logic               args_ok;
  logic               slot_ok;
  logic [SLOT_IW-1:0] rd_idx;
  logic [SLOT_W-1:0]  tgt;
  logic [LINE_W-1:0]  tgt_line;
  logic               rd_busy;

  always_comb begin
    args_ok = ({1'b0, src_q} < (SRC_W + 1)'(NUM_SOURCES)) && (handler_q != '0);
    slot_ok = ({1'b0, slot_q} < (SLOT_W + 1)'(SLOTS));
    rd_idx  = (cmd_q == CMD_ALLOC) ? found_idx : slot_q[SLOT_IW-1:0];
    tgt     = (cmd_q == CMD_ALLOC) ? SLOT_W'(found_idx) : slot_q;
    if ({1'b0, tgt} < (SLOT_W + 1)'(LINE_REGS)) begin
      tgt_line = line_reg[tgt];
    end else begin
      tgt_line = '0;
    end
    rd_busy = slot_ok && slot_busy[rd_idx];
  end

  // Result decision and table update requests
  logic [CODE_W-1:0] r_code;
  logic [SLOT_W-1:0] r_slot;
  logic              r_rv;
  logic [SRC_W-1:0]  r_rsrc;
  logic [LINE_W-1:0] r_rval;
  logic [ACT_W-1:0]  r_lact;
  logic [LINE_W-1:0] r_lnum;
  logic              r_disp;
  logic [WORD_W-1:0] r_dh;
  logic [WORD_W-1:0] r_da;
  logic              do_alloc;
  logic              do_free;
  logic              do_enable;
  logic              do_disable;

  always_comb begin
    r_code     = RC_OK;
    r_slot     = '0;
    r_rv       = 1'b0;
    r_rsrc     = '0;
    r_rval     = '0;
    r_lact     = LA_NONE;
    r_lnum     = '0;
    r_disp     = 1'b0;
    r_dh       = '0;
    r_da       = '0;
    do_alloc   = 1'b0;
    do_free    = 1'b0;
    do_enable  = 1'b0;
    do_disable = 1'b0;
    case (cmd_q) inside
      CMD_ALLOC: begin
        if (!args_ok) begin
          r_code = RC_INVALID;
        end else if (dup) begin
          r_code = RC_HELD;
        end else if (!found) begin
          r_code = RC_FULL;
        end else begin
          do_alloc = 1'b1;
          r_slot   = tgt;
          r_rv     = 1'b1;
          r_rsrc   = src_q;
          r_rval   = tgt_line;
          r_lact   = LA_ENABLE;
          r_lnum   = tgt_line;
        end
      end
      CMD_FREE, CMD_ENABLE, CMD_DISABLE: begin
        r_slot = slot_q;
        if (!rd_busy) begin
          r_code = RC_INVALID;
        end else begin
          r_rv   = 1'b1;
          r_rsrc = slot_source[rd_idx];
          r_lnum = tgt_line;
          if (cmd_q == CMD_ENABLE) begin
            do_enable = 1'b1;
            r_rval    = tgt_line;
            r_lact    = LA_ENABLE;
          end else begin
            do_disable = 1'b1;
            do_free    = (cmd_q == CMD_FREE);
            r_rval     = parked;
            r_lact     = LA_DISABLE;
          end
        end
      end
      CMD_EVENT: begin
        r_slot = slot_q;
        if (!slot_ok) begin
          r_code = RC_INVALID;
        end else if (slot_busy[rd_idx] && slot_enabled[rd_idx] &&
                     (slot_handler[rd_idx] != '0) &&
                     (!slot_fon[rd_idx] || ((status_q & slot_mask[rd_idx]) != '0))) begin
          r_disp = 1'b1;
          r_dh   = slot_handler[rd_idx];
          r_da   = slot_arg[rd_idx];
        end
      end
      default: begin
        r_code = RC_INVALID;
        r_slot = slot_q;
      end
    endcase
  end

  // Update the slot table on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i]    <= 1'b0;
        slot_enabled[i] <= 1'b0;
        slot_source[i]  <= '0;
        slot_fon[i]     <= 1'b0;
        slot_mask[i]    <= '0;
        slot_handler[i] <= '0;
        slot_arg[i]     <= '0;
      end
    end else if (ctrl_cmd.exec) begin
      if (do_alloc) begin
        slot_busy[rd_idx]    <= 1'b1;
        slot_enabled[rd_idx] <= 1'b1;
        slot_source[rd_idx]  <= src_q;
        slot_fon[rd_idx]     <= fon_q;
        slot_mask[rd_idx]    <= fmask_q;
        slot_handler[rd_idx] <= handler_q;
        slot_arg[rd_idx]     <= arg_q;
      end
      if (do_enable) begin
        slot_enabled[rd_idx] <= 1'b1;
      end
      if (do_disable) begin
        slot_enabled[rd_idx] <= 1'b0;
      end
      if (do_free) begin
        slot_busy[rd_idx]    <= 1'b0;
        slot_fon[rd_idx]     <= 1'b0;
        slot_mask[rd_idx]    <= '0;
        slot_handler[rd_idx] <= '0;
        slot_arg[rd_idx]     <= '0;
      end
    end
  end

  // Result register: load on execute, drop when the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec) begin
      result_code      <= r_code;
      slot_out         <= r_slot;
      route_valid      <= r_rv;
      route_source     <= r_rsrc;
      route_value      <= r_rval;
      line_action      <= r_lact;
      line_number      <= r_lnum;
      dispatch         <= r_disp;
      dispatch_handler <= r_dh;
      dispatch_arg     <= r_da;
    end
  end

  // A successful alloc leaves its slot busy
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (ctrl_cmd.exec && do_alloc) |=> slot_busy[found_idx])
    else $error("allocated slot not marked busy");

  // Routing writes and dispatches only come with a good result code
  a_action_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (route_valid || dispatch)) |-> (result_code == RC_OK))
    else $error("action reported with an error code");

  // Alloc never reports a slot it did not find free
  a_alloc_found: assert property (@(posedge clk) disable iff (rst)
    (ctrl_cmd.exec && do_alloc) |-> (found && !dup))
    else $error("alloc committed without a free slot");

endmodule

// File: design/interrupt_slot_allocator.sv
// Top level of the interrupt slot allocator.
// Depends on isa_pkg, isa_ctrl and isa_datapath.
//
// Usage:
//   Commands arrive on the input channel (in_valid / in_stall); one result
//   transaction leaves on the output channel (out_valid / out_stall) for
//   every accepted command. A transaction moves at a clock edge with valid
//   high and stall low.
//   An alloc with a usable source and handler walks the table one slot per
//   cycle for the duplicate check and the first free slot before it
//   executes; every other command executes directly. One command is in
//   work at a time; the next one is accepted the cycle after a result is
//   registered, even while it waits at the output.
//   When the receiver stalls, the result register holds its contents; a
//   following command finishes its work and then waits until the register
//   is taken.
//   Line registers are written through cfg_we / cfg_index / cfg_data; the
//   user must write them only while the block is idle, which the block
//   does not enforce. Synchronous reset (rst) empties the slot table,
//   restores the line registers to 16..21 and parked to 22, drops out_valid.

module interrupt_slot_allocator
  import isa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [LINE_W-1:0]   cfg_data,
  // command channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SRC_W-1:0]    source,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [WORD_W-1:0]   handler_ref,
  input  logic [WORD_W-1:0]   arg_ref,
  input  logic                filter_on,
  input  logic [WORD_W-1:0]   filter_mask,
  input  logic [WORD_W-1:0]   status_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   result_code,
  output logic [SLOT_W-1:0]   slot_out,
  output logic                route_valid,
  output logic [SRC_W-1:0]    route_source,
  output logic [LINE_W-1:0]   route_value,
  output logic [ACT_W-1:0]    line_action,
  output logic [LINE_W-1:0]   line_number,
  output logic                dispatch,
  output logic [WORD_W-1:0]   dispatch_handler,
  output logic [WORD_W-1:0]   dispatch_arg
);

  isa_cmd_t  ctrl_cmd;
  isa_stat_t stat;

  isa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl_cmd  (ctrl_cmd)
  );

  isa_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctrl_cmd         (ctrl_cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .source           (source),
    .slot             (slot),
    .handler_ref      (handler_ref),
    .arg_ref          (arg_ref),
    .filter_on        (filter_on),
    .filter_mask      (filter_mask),
    .status_value     (status_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_code      (result_code),
    .slot_out         (slot_out),
    .route_valid      (route_valid),
    .route_source     (route_source),
    .route_value      (route_value),
    .line_action      (line_action),
    .line_number      (line_number),
    .dispatch         (dispatch),
    .dispatch_handler (dispatch_handler),
    .dispatch_arg     (dispatch_arg)
  );

endmodule

// File: bench/interrupt_slot_allocator_tb.sv
// Self-checking testbench for the interrupt slot allocator.
// Depends on isa_pkg and interrupt_slot_allocator; predicts every result
// transaction from a local copy of the slot table and the line registers.

module interrupt_slot_allocator_tb;
  import isa_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_RESERVED = 3'd7;
  localparam logic [CFG_IW-1:0] REG_SPARE    = 3'd7;
  localparam logic [LINE_W-1:0] LINE_MAX     = 6'd47;
  localparam int                SLOT_MAX     = (1 << SLOT_W) - 1;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [SRC_W-1:0]  src;
    logic [SLOT_W-1:0] slot_idx;
    logic [WORD_W-1:0] handler;
    logic [WORD_W-1:0] arg;
    logic              filt_en;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] status;
  } slot_command_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot_id;
    logic              route_wr;
    logic [SRC_W-1:0]  route_src;
    logic [LINE_W-1:0] route_val;
    logic [ACT_W-1:0]  action;
    logic [LINE_W-1:0] action_line;
    logic              fire;
    logic [WORD_W-1:0] fire_handler;
    logic [WORD_W-1:0] fire_arg;
  } slot_result_t;

  logic                clk;
  logic                rst          = 1'b1;
  logic                cfg_we       = 1'b0;
  logic [CFG_IW-1:0]   cfg_index    = '0;
  logic [LINE_W-1:0]   cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd          = '0;
  logic [SRC_W-1:0]    source       = '0;
  logic [SLOT_W-1:0]   slot         = '0;
  logic [WORD_W-1:0]   handler_ref  = '0;
  logic [WORD_W-1:0]   arg_ref      = '0;
  logic                filter_on    = 1'b0;
  logic [WORD_W-1:0]   filter_mask  = '0;
  logic [WORD_W-1:0]   status_value = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [CODE_W-1:0]   result_code;
  logic [SLOT_W-1:0]   slot_out;
  logic                route_valid;
  logic [SRC_W-1:0]    route_source;
  logic [LINE_W-1:0]   route_value;
  logic [ACT_W-1:0]    line_action;
  logic [LINE_W-1:0]   line_number;
  logic                dispatch;
  logic [WORD_W-1:0]   dispatch_handler;
  logic [WORD_W-1:0]   dispatch_arg;

  // Local copy of the slot table and line registers
  logic              held           [SLOTS];
  logic              armed          [SLOTS];
  logic [SRC_W-1:0]  held_src       [SLOTS];
  logic              gated          [SLOTS];
  logic [WORD_W-1:0] gate_mask      [SLOTS];
  logic [WORD_W-1:0] stored_handler [SLOTS];
  logic [WORD_W-1:0] stored_arg     [SLOTS];
  logic [LINE_W-1:0] wired_line     [LINE_REGS];
  logic [LINE_W-1:0] parked_value;

  slot_result_t pending_results[$];
  int           error_count      = 0;
  int           sender_idle_pct  = 38;
  int           receiver_idle_pct = 69;

  interrupt_slot_allocator DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  function automatic logic [LINE_W-1:0] line_for(input int s);
    return (s < LINE_REGS) ? wired_line[s] : '0;
  endfunction

  task automatic clear_table_model();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      held[i] = 1'b0;
      armed[i] = 1'b0;
      held_src[i] = '0;
      gated[i] = 1'b0;
      gate_mask[i] = '0;
      stored_handler[i] = '0;
      stored_arg[i] = '0;
    end
    for (i = 0; i < LINE_REGS; i++) wired_line[i] = LINE_W'(LINE_RESET_BASE + i);
    parked_value = PARKED_RESET;
  endtask

  // Work out the result of one command and advance the table copy
  function automatic slot_result_t apply_command(input slot_command_t c);
    slot_result_t r;
    int           i;
    int           free_idx;
    int           s;
    r = '0;
    free_idx = -1;
    s = int'(c.slot_idx);
    case (c.op) inside
      CMD_ALLOC: begin
        if (c.src >= NUM_SOURCES || c.handler == '0) begin
          r.code = RC_INVALID;
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (held[i] && held_src[i] == c.src) r.code = RC_HELD;
          end
          if (r.code == RC_OK) begin
            // lowest free slot wins
            for (i = SLOTS - 1; i >= 0; i--) begin
              if (!held[i]) free_idx = i;
            end
            if (free_idx < 0) begin
              r.code = RC_FULL;
            end else begin
              held[free_idx] = 1'b1;
              armed[free_idx] = 1'b1;
              held_src[free_idx] = c.src;
              gated[free_idx] = c.filt_en;
              gate_mask[free_idx] = c.mask;
              stored_handler[free_idx] = c.handler;
              stored_arg[free_idx] = c.arg;
              r.slot_id = SLOT_W'(free_idx);
              r.route_wr = 1'b1;
              r.route_src = c.src;
              r.route_val = line_for(free_idx);
              r.action = LA_ENABLE;
              r.action_line = line_for(free_idx);
            end
          end
        end
      end
      CMD_FREE, CMD_ENABLE, CMD_DISABLE: begin
        r.slot_id = c.slot_idx;
        if (s >= SLOTS || !held[s]) begin
          r.code = RC_INVALID;
        end else begin
          r.route_wr = 1'b1;
          r.route_src = held_src[s];
          r.action_line = line_for(s);
          if (c.op == CMD_ENABLE) begin
            armed[s] = 1'b1;
            r.route_val = line_for(s);
            r.action = LA_ENABLE;
          end else begin
            armed[s] = 1'b0;
            r.route_val = parked_value;
            r.action = LA_DISABLE;
            // free keeps the source entry but drops the rest
            if (c.op == CMD_FREE) begin
              held[s] = 1'b0;
              stored_handler[s] = '0;
              stored_arg[s] = '0;
              gated[s] = 1'b0;
              gate_mask[s] = '0;
            end
          end
        end
      end
      CMD_EVENT: begin
        r.slot_id = c.slot_idx;
        if (s >= SLOTS) begin
          r.code = RC_INVALID;
        end else if (held[s] && armed[s] && stored_handler[s] != '0 &&
                     (!gated[s] || (c.status & gate_mask[s]) != '0)) begin
          r.fire = 1'b1;
          r.fire_handler = stored_handler[s];
          r.fire_arg = stored_arg[s];
        end
      end
      default: begin
        r.code = RC_INVALID;
        r.slot_id = c.slot_idx;
      end
    endcase
    return r;
  endfunction

  // Drive one command, hold it until taken, then record its expected result
  task automatic issue_command(input slot_command_t c);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    cmd <= c.op;
    source <= c.src;
    slot <= c.slot_idx;
    handler_ref <= c.handler;
    arg_ref <= c.arg;
    filter_on <= c.filt_en;
    filter_mask <= c.mask;
    status_value <= c.status;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_command(c));
  endtask

  task automatic issue_alloc(input logic [SRC_W-1:0] src, input logic [WORD_W-1:0] handler,
                             input logic [WORD_W-1:0] arg, input logic filt_en,
                             input logic [WORD_W-1:0] mask);
    slot_command_t c;
    c = '0;
    c.op = CMD_ALLOC;
    c.src = src;
    c.handler = handler;
    c.arg = arg;
    c.filt_en = filt_en;
    c.mask = mask;
    issue_command(c);
  endtask

  task automatic issue_slot_cmd(input logic [CMD_W-1:0] op, input logic [SLOT_W-1:0] s,
                                input logic [WORD_W-1:0] status);
    slot_command_t c;
    c = '0;
    c.op = op;
    c.slot_idx = s;
    c.status = status;
    issue_command(c);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IW-1:0] idx, input logic [LINE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < LINE_REGS) wired_line[idx] = val;
    else if (idx == REG_PARKED) parked_value = val;
  endtask

  task automatic close_register_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SLOT_W-1:0] pick_busy_slot();
    int busy_list[$];
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (held[i]) busy_list.push_back(i);
    end
    if (busy_list.size() == 0 || $urandom_range(99) < 10) begin
      return SLOT_W'($urandom_range(0, SLOT_MAX));
    end
    return SLOT_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
  endfunction

  // Mostly well-formed commands aimed at live slots, the rest pure noise
  task automatic make_random_command(output slot_command_t c);
    int pick;
    c.op = CMD_W'($urandom_range(0, 7));
    c.src = SRC_W'($urandom);
    c.slot_idx = SLOT_W'($urandom);
    c.handler = $urandom;
    c.arg = $urandom;
    c.filt_en = 1'($urandom);
    c.mask = $urandom;
    c.status = $urandom;
    if ($urandom_range(99) < 15) return;
    pick = $urandom_range(99);
    if (pick < 30) begin
      c.op = CMD_ALLOC;
      // a small source pool makes duplicates and a full table common
      c.src = SRC_W'(($urandom_range(99) < 70) ? $urandom_range(0, 11)
                                               : $urandom_range(0, NUM_SOURCES - 1));
      if (c.handler == '0) c.handler = 32'h1;
      if ($urandom_range(1)) c.mask = 32'h1 << $urandom_range(0, 31);
    end else if (pick < 67) begin
      c.op = (pick < 45) ? CMD_FREE : (pick < 55) ? CMD_ENABLE : CMD_DISABLE;
      c.slot_idx = pick_busy_slot();
    end else begin
      c.op = CMD_EVENT;
      c.slot_idx = pick_busy_slot();
      case ($urandom_range(2))
        0: c.status = '0;
        1: c.status = 32'h1 << $urandom_range(0, 31);
        default: c.status = $urandom;
      endcase
    end
  endtask

  task automatic run_traffic(input int count);
    slot_command_t c;
    int            n;
    for (n = 0; n < count; n++) begin
      // let the block run dry once mid-phase
      if (n == count / 2) hold_until_drained();
      make_random_command(c);
      issue_command(c);
    end
    hold_until_drained();
  endtask

  // Range, handler, duplicate and full-table rules of alloc
  task automatic test_alloc_rules();
    issue_alloc(8'd0, 32'h1, 32'h0, 1'b0, 32'h0);
    issue_alloc(SRC_W'(NUM_SOURCES - 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    issue_alloc(SRC_W'(NUM_SOURCES), 32'h5, 32'h6, 1'b0, 32'h0);
    issue_alloc(8'hFF, 32'h5, 32'h6, 1'b0, 32'h0);
    issue_alloc(8'd7, 32'h0, 32'h6, 1'b0, 32'h0);
    issue_alloc(8'd0, 32'h2, 32'h3, 1'b0, 32'h0);
    issue_alloc(8'd1, 32'hA5A5_0001, 32'h11, 1'b0, 32'h0);
    issue_alloc(8'd2, 32'h5A5A_0002, 32'h22, 1'b1, 32'h8000_0000);
    issue_alloc(8'd3, 32'h0000_0003, 32'h33, 1'b0, 32'h0);
    issue_alloc(8'd4, 32'h0000_0004, 32'h44, 1'b1, 32'h0000_0010);
    issue_alloc(8'd5, 32'h0000_0005, 32'h55, 1'b0, 32'h0);
  endtask

  // Free, enable, disable, events and bad slots
  task automatic test_slot_commands();
    issue_slot_cmd(CMD_EVENT, 3'd0, 32'h0);
    issue_slot_cmd(CMD_EVENT, 3'd1, 32'h0);
    issue_slot_cmd(CMD_EVENT, 3'd1, 32'hFFFF_FFFF);
    issue_slot_cmd(CMD_DISABLE, 3'd0, 32'h0);
    issue_slot_cmd(CMD_EVENT, 3'd0, 32'h0);
    issue_slot_cmd(CMD_ENABLE, 3'd0, 32'h0);
    issue_slot_cmd(CMD_FREE, 3'd2, 32'h0);
    issue_slot_cmd(CMD_FREE, 3'd2, 32'h0);
    issue_slot_cmd(CMD_ENABLE, 3'd2, 32'h0);
    issue_slot_cmd(CMD_EVENT, 3'd2, 32'hFFFF_FFFF);
    issue_slot_cmd(CMD_DISABLE, SLOT_W'(SLOTS), 32'h0);
    issue_slot_cmd(CMD_EVENT, SLOT_W'(SLOT_MAX), 32'h0);
    issue_slot_cmd(CMD_RESERVED, 3'd0, 32'h0);
    // a freed slot keeps its source entry but is no longer busy, so this source is free again
    issue_alloc(8'd1, 32'h77, 32'h88, 1'b0, 32'h0);
    hold_until_drained();
  endtask

  // Lowest lines and parked value 47, receiver-side stalls outweigh sender-side gaps
  task automatic test_low_lines_sender_idle();
    int i;
    sender_idle_pct = 38;
    receiver_idle_pct = 69;
    for (i = 0; i < LINE_REGS; i++) set_register(CFG_IW'(i), '0);
    set_register(REG_PARKED, LINE_MAX);
    close_register_writes();
    run_traffic(310);
  endtask

  // Lines at 47 and lowest parked value, sender-side gaps outweigh receiver-side stalls
  task automatic test_high_lines_receiver_idle();
    int i;
    sender_idle_pct = 69;
    receiver_idle_pct = 38;
    for (i = 0; i < LINE_REGS; i++) set_register(CFG_IW'(i), LINE_MAX);
    set_register(REG_PARKED, '0);
    close_register_writes();
    run_traffic(310);
  endtask

  // Mixed lines, the unused register index, back-to-back traffic
  task automatic test_mixed_lines_full_rate();
    int i;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    // slot 0 lands in 16..31 so every data bit toggles across phases
    set_register(CFG_IW'(0), LINE_W'($urandom_range(16, 31)));
    for (i = 1; i < LINE_REGS; i++) begin
      set_register(CFG_IW'(i), LINE_W'($urandom_range(0, LINE_MAX)));
    end
    set_register(REG_PARKED, LINE_W'($urandom_range(0, LINE_MAX)));
    set_register(REG_SPARE, LINE_W'($urandom_range(0, LINE_MAX)));
    close_register_writes();
    run_traffic(310);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare every taken result transaction with the oldest expectation
  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {result_code, slot_out, route_valid, route_source, route_value, line_action,
             line_number, dispatch, dispatch_handler, dispatch_arg};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_code", WORD_W'(want.code), WORD_W'(got.code));
        check_field("slot_out", WORD_W'(want.slot_id), WORD_W'(got.slot_id));
        check_field("route_valid", WORD_W'(want.route_wr), WORD_W'(got.route_wr));
        check_field("route_source", WORD_W'(want.route_src), WORD_W'(got.route_src));
        check_field("route_value", WORD_W'(want.route_val), WORD_W'(got.route_val));
        check_field("line_action", WORD_W'(want.action), WORD_W'(got.action));
        check_field("line_number", WORD_W'(want.action_line), WORD_W'(got.action_line));
        check_field("dispatch", WORD_W'(want.fire), WORD_W'(got.fire));
        check_field("dispatch_handler", want.fire_handler, got.fire_handler);
        check_field("dispatch_arg", want.fire_arg, got.fire_arg);
      end
    end
  end

  initial begin
    clear_table_model();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_alloc_rules();
    test_slot_commands();
    test_low_lines_sender_idle();
    test_high_lines_receiver_idle();
    test_mixed_lines_full_rate();
    hold_until_drained();
    repeat (2 * (SLOTS + 2)) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
